// ===== hw/rtl/palette_nearest_color_match_defines.svh =====
// ---------------------------------------------------------------------------
// Palette nearest color match: assertion macros
// Concurrent assertion wrappers used by the controller.
// ---------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_MATCH_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MATCH_DEFINES_SVH

`ifndef ASSERT_OFF
`define PNCM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pncm assertion failed");
`define PNCM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pncm assertion failed");
`else
`define PNCM_ASSERT(lbl, clk, rst_n, prop)
`define PNCM_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/pncm_pkg.sv =====
// ---------------------------------------------------------------------------
// Palette nearest color match: package
// Item types, controller/datapath interface structs and cube color helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pncm_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned CubeIdxW = 8;
  localparam int unsigned CubeSize = 256;
  localparam int unsigned ColorW   = 3 * LevelW;
  localparam int unsigned ResW     = CubeIdxW + 1;
  localparam int unsigned SqW      = 2 * LevelW;
  localparam int unsigned ErrW     = 18;
  localparam int unsigned RgW      = 64;
  localparam int unsigned BlueW    = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ErrW-1:0]     MaxError = ErrW'(3 * 256 * 256);
  localparam logic [CubeIdxW-1:0] CubeLast = CubeIdxW'(CubeSize - 1);
  localparam logic [RgW-1:0]      RgReset   = 64'hFFDB_B692_6D49_2400;
  localparam logic [BlueW-1:0]    BlueReset = 32'hFFAA_5900;

  localparam logic [CfgIdxW-1:0] CfgRgLevels   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlueLevels = 1'b1;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic              final_color;
  } in_item_t;

  typedef struct packed {
    logic [CubeIdxW-1:0] cube_index;
    logic                exact;
    logic                last_result;
  } out_item_t;

  typedef struct packed {
    logic                color_we;
    logic                used_clear;
    logic                p1_scan;
    logic                best_init;
    logic                scan_valid;
    logic                p2_write;
    logic                out_load;
    logic                out_last;
    logic [CubeIdxW-1:0] j;
  } cmd_t;

  typedef struct packed {
    logic p1_match;
    logic res_exact;
  } sts_t;

  function automatic logic [ColorW-1:0] cube_color(input logic [RgW-1:0]      rg,
                                                   input logic [BlueW-1:0]    bl,
                                                   input logic [CubeIdxW-1:0] j);
    logic [2:0] kr;
    logic [2:0] kg;
    logic [1:0] kb;
    kr = j[2:0];
    kg = j[5:3];
    kb = j[7:6];
    return {rg[LevelW*kr +: LevelW], rg[LevelW*kg +: LevelW], bl[LevelW*kb +: LevelW]};
  endfunction

endpackage

// ===== hw/rtl/pncm_ram.sv =====
// ---------------------------------------------------------------------------
// Palette nearest color match: generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pncm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pncm_dp.sv =====
// ---------------------------------------------------------------------------
// Palette nearest color match: datapath
// Level registers, color and result stores, used map, distance pipeline,
// best-candidate tracking and output item register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pncm_dp import pncm_pkg::*; #(
  parameter int unsigned MaxReserved = 32,
  localparam int unsigned AddrW = (MaxReserved > 1) ? $clog2(MaxReserved) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  in_item_t            in_item_i,
  input  cmd_t                cmd_i,
  input  logic [AddrW-1:0]    load_addr_i,
  input  logic [AddrW-1:0]    color_addr_i,
  output sts_t                sts_o,
  output out_item_t           out_item_o
);

  logic [RgW-1:0]      rg_q;
  logic [BlueW-1:0]    blue_q;

  logic                used_rdata;
  logic                used_we;
  logic [CubeIdxW-1:0] used_waddr;
  logic                used_wdata;

  logic [ColorW-1:0] color_rdata;
  logic [ResW-1:0]   res_rdata;
  logic [ResW-1:0]   res_wdata;
  logic              res_we;

  logic [ColorW-1:0] cc;
  logic              match;
  logic [LevelW-1:0] dr;
  logic [LevelW-1:0] dg;
  logic [LevelW-1:0] db;

  logic [SqW-1:0]      sq_r_q;
  logic [SqW-1:0]      sq_g_q;
  logic [SqW-1:0]      sq_b_q;
  logic                s1_valid_q;
  logic [CubeIdxW-1:0] s1_j_q;
  logic [ErrW-1:0]     err;

  logic [ErrW-1:0]     best_q;
  logic [CubeIdxW-1:0] best_j_q;
  logic                found_q;
  out_item_t           out_q;

  // level registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rg_q   <= RgReset;
      blue_q <= BlueReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRgLevels:   rg_q   <= cfg_wdata_i;
        CfgBlueLevels: blue_q <= cfg_wdata_i[BlueW-1:0];
        default: ;
      endcase
    end
  end

  pncm_ram #(
    .Width (ColorW),
    .Depth (MaxReserved)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.color_we),
    .waddr_i (load_addr_i),
    .wdata_i ({in_item_i.red, in_item_i.green, in_item_i.blue}),
    .raddr_i (color_addr_i),
    .rdata_o (color_rdata)
  );

  pncm_ram #(
    .Width (ResW),
    .Depth (MaxReserved)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (color_addr_i),
    .wdata_i (res_wdata),
    .raddr_i (color_addr_i),
    .rdata_o (res_rdata)
  );

  // used map: read data lines up with the distance stage
  pncm_ram #(
    .Width (1),
    .Depth (CubeSize)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (cmd_i.j),
    .rdata_o (used_rdata)
  );

  assign cc    = cube_color(rg_q, blue_q, cmd_i.j);
  assign match = (cc == color_rdata);

  assign dr = (color_rdata[23:16] > cc[23:16]) ? color_rdata[23:16] - cc[23:16]
                                               : cc[23:16] - color_rdata[23:16];
  assign dg = (color_rdata[15:8] > cc[15:8]) ? color_rdata[15:8] - cc[15:8]
                                             : cc[15:8] - color_rdata[15:8];
  assign db = (color_rdata[7:0] > cc[7:0]) ? color_rdata[7:0] - cc[7:0]
                                           : cc[7:0] - color_rdata[7:0];

  // pass one writes on a hit or at the end of the walk; pass two at its end
  always_comb begin
    res_we = (cmd_i.p1_scan && (match || (cmd_i.j == CubeLast))) || cmd_i.p2_write;
    if (cmd_i.p2_write) begin
      res_wdata = {1'b0, best_j_q};
    end else if (match) begin
      res_wdata = {1'b1, cmd_i.j};
    end else begin
      res_wdata = '0;
    end
  end

  always_comb begin
    used_we    = cmd_i.used_clear || (cmd_i.p1_scan && match) || (cmd_i.p2_write && found_q);
    used_waddr = cmd_i.p2_write ? best_j_q : cmd_i.j;
    used_wdata = !cmd_i.used_clear;
  end

  // distance stage
  always_ff @(posedge clk_i) begin
    sq_r_q    <= SqW'(dr) * SqW'(dr);
    sq_g_q    <= SqW'(dg) * SqW'(dg);
    sq_b_q    <= SqW'(db) * SqW'(db);
    s1_j_q    <= cmd_i.j;
  end

  assign err = ErrW'(sq_r_q) + ErrW'(sq_g_q) + ErrW'(sq_b_q);

  // compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      best_q     <= MaxError;
      best_j_q   <= '0;
      found_q    <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.scan_valid;
      if (cmd_i.best_init) begin
        best_q   <= MaxError;
        best_j_q <= '0;
        found_q  <= 1'b0;
      end else if (s1_valid_q && !used_rdata && (err < best_q)) begin
        best_q   <= err;
        best_j_q <= s1_j_q;
        found_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.cube_index  <= res_rdata[CubeIdxW-1:0];
      out_q.exact       <= res_rdata[ResW-1];
      out_q.last_result <= cmd_i.out_last;
    end
  end

  assign sts_o.p1_match  = match;
  assign sts_o.res_exact = res_rdata[ResW-1];
  assign out_item_o      = out_q;

endmodule

// ===== hw/rtl/pncm_ctrl.sv =====
// ---------------------------------------------------------------------------
// Palette nearest color match: controller
// Sequences loading, the exact pass, the nearest pass and result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_nearest_color_match_defines.svh"

module pncm_ctrl import pncm_pkg::*; #(
  parameter int unsigned MaxReserved = 32,
  localparam int unsigned AddrW = (MaxReserved > 1) ? $clog2(MaxReserved) : 1,
  localparam int unsigned CntW  = $clog2(MaxReserved + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_final_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o,
  output logic [AddrW-1:0] load_addr_o,
  output logic [AddrW-1:0] color_addr_o
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLR,
    S_P1_RD,
    S_P1_SCAN,
    S_P2_RD,
    S_P2_CHK,
    S_P2_SCAN,
    S_P2_DRAIN,
    S_P2_WR,
    S_O_RD,
    S_O_LD,
    S_O_WAIT
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     n_q;
  logic [CntW-1:0]     i_q;
  logic [CubeIdxW-1:0] j_q;
  logic                out_valid_q;

  logic in_acc;
  logic room;
  logic last_color;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (count_q < CntW'(MaxReserved));
  assign last_color = ((i_q + CntW'(1)) == n_q);

  always_comb begin
    cmd_o            = '0;
    cmd_o.color_we   = in_acc && room;
    cmd_o.used_clear = (state_q == S_CLR);
    cmd_o.p1_scan    = (state_q == S_P1_SCAN);
    cmd_o.best_init  = (state_q == S_P2_CHK);
    cmd_o.scan_valid = (state_q == S_P2_SCAN);
    cmd_o.p2_write   = (state_q == S_P2_WR);
    cmd_o.out_load   = (state_q == S_O_LD);
    cmd_o.out_last   = last_color;
    cmd_o.j          = j_q;
  end

  assign load_addr_o  = count_q[AddrW-1:0];
  assign color_addr_o = i_q[AddrW-1:0];
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (in_final_i) begin
              n_q     <= count_q + CntW'(room);
              count_q <= '0;
              i_q     <= '0;
              j_q     <= '0;
              state_q <= S_CLR;
            end else begin
              count_q <= count_q + CntW'(room);
            end
          end
        end
        // one used-map entry cleared per cycle
        S_CLR: begin
          j_q <= j_q + CubeIdxW'(1);
          if (j_q == CubeLast) begin
            state_q <= S_P1_RD;
          end
        end
        S_P1_RD: state_q <= S_P1_SCAN;
        S_P1_SCAN: begin
          if (sts_i.p1_match || (j_q == CubeLast)) begin
            j_q <= '0;
            if (last_color) begin
              i_q     <= '0;
              state_q <= S_P2_RD;
            end else begin
              i_q     <= i_q + CntW'(1);
              state_q <= S_P1_RD;
            end
          end else begin
            j_q <= j_q + CubeIdxW'(1);
          end
        end
        S_P2_RD: state_q <= S_P2_CHK;
        S_P2_CHK: begin
          if (sts_i.res_exact) begin
            if (last_color) begin
              i_q     <= '0;
              state_q <= S_O_RD;
            end else begin
              i_q     <= i_q + CntW'(1);
              state_q <= S_P2_RD;
            end
          end else begin
            j_q     <= '0;
            state_q <= S_P2_SCAN;
          end
        end
        S_P2_SCAN: begin
          j_q <= j_q + CubeIdxW'(1);
          if (j_q == CubeLast) begin
            state_q <= S_P2_DRAIN;
          end
        end
        S_P2_DRAIN: state_q <= S_P2_WR;
        S_P2_WR: begin
          if (last_color) begin
            i_q     <= '0;
            state_q <= S_O_RD;
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_P2_RD;
          end
        end
        S_O_RD: state_q <= S_O_LD;
        S_O_LD: begin
          out_valid_q <= 1'b1;
          state_q     <= S_O_WAIT;
        end
        S_O_WAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (last_color) begin
              state_q <= S_LOAD;
            end else begin
              i_q     <= i_q + CntW'(1);
              state_q <= S_O_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `PNCM_ASSERT_NR(a_no_load_while_out, clk_i, out_valid_o |-> in_stall_o)
  `PNCM_ASSERT(a_count_range, clk_i, rst_ni, (count_q <= CntW'(MaxReserved)) && (n_q <= CntW'(MaxReserved)))
  `PNCM_ASSERT(a_scan_in_batch, clk_i, rst_ni, (state_q == S_P1_SCAN || state_q == S_P2_SCAN) |-> (i_q < n_q))
  `PNCM_ASSERT(a_last_done, clk_i, rst_ni, (out_valid_o && !out_stall_i && last_color) |=> ((state_q == S_LOAD) && (count_q == '0) && !out_valid_o))

endmodule

// ===== hw/rtl/palette_nearest_color_match.sv =====
// Load: one item per cycle while in the load state; results for the held colors
// follow the final item. After it: clear of the used-entry map, exact pass,
// nearest pass (one cube entry per cycle, two-stage distance pipe).
// Output: each result is read from the registered result store and held until taken.
// Reset: gamma 1.0 level tables, empty color store; used map cleared per batch.
// ---------------------------------------------------------------------------
// Palette nearest color match: top level
// Matches up to MaxReserved colors onto a 3:3:2 color cube, exact first,
// then nearest unused entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_nearest_color_match import pncm_pkg::*; #(
  parameter int unsigned MaxReserved = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = (MaxReserved > 1) ? $clog2(MaxReserved) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [AddrW-1:0] load_addr;
  logic [AddrW-1:0] color_addr;

  pncm_ctrl #(
    .MaxReserved (MaxReserved)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_final_i   (in_item_i.final_color),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .load_addr_o  (load_addr),
    .color_addr_o (color_addr)
  );

  pncm_dp #(
    .MaxReserved (MaxReserved)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_item_i    (in_item_i),
    .cmd_i        (cmd),
    .load_addr_i  (load_addr),
    .color_addr_i (color_addr),
    .sts_o        (sts),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== sim/pncm_checker.sv =====
// ---------------------------------------------------------------------------
// Palette nearest color match: result checker
// Watches the color, result and level-register ports. It keeps its own copy
// of the level tables and the color store, works out the cube entries of
// each batch when the last color is accepted, and compares every result
// item with the oldest expected one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pncm_checker import pncm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         errors_o,
  output int unsigned         backlog_o
);

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned PrintCap   = 100;
  localparam int unsigned WorstDist  = 3 * 256 * 256;

  logic [RgW-1:0]    rg_lv   = RgReset;
  logic [BlueW-1:0]  blue_lv = BlueReset;
  logic [ColorW-1:0] held_colors [StoreDepth];
  int unsigned       held_n = 0;
  out_item_t         assigned_q [$];

  function automatic int unsigned sq_dist(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors_o < PrintCap) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
    errors_o++;
  endtask

  // exact pass first, then nearest unused entry in load order
  task automatic assign_entries();
    logic [ColorW-1:0] cube [CubeSize];
    bit                taken [CubeSize];
    logic [7:0]        pick [StoreDepth];
    bit                hit [StoreDepth];
    logic [7:0]        jj;
    logic [ColorW-1:0] c;
    int unsigned       best;
    int unsigned       err;
    out_item_t         res;
    for (int j = 0; j < CubeSize; j++) begin
      jj = 8'(j);
      cube[j] = {rg_lv[8*jj[2:0] +: 8], rg_lv[8*jj[5:3] +: 8], blue_lv[8*jj[7:6] +: 8]};
      taken[j] = 1'b0;
    end
    for (int i = 0; i < held_n; i++) begin
      hit[i] = 1'b0;
      pick[i] = '0;
      for (int j = 0; j < CubeSize; j++) begin
        if (cube[j] == held_colors[i]) begin
          hit[i] = 1'b1;
          pick[i] = 8'(j);
          taken[j] = 1'b1;
          break;
        end
      end
    end
    for (int i = 0; i < held_n; i++) begin
      if (!hit[i]) begin
        best = WorstDist;
        c = held_colors[i];
        for (int j = 0; j < CubeSize; j++) begin
          if (!taken[j]) begin
            err = sq_dist(c[23:16], cube[j][23:16]) + sq_dist(c[15:8], cube[j][15:8]) +
                  sq_dist(c[7:0], cube[j][7:0]);
            if (err < best) begin
              best = err;
              pick[i] = 8'(j);
            end
          end
        end
        if (best < WorstDist) begin
          taken[pick[i]] = 1'b1;
        end
      end
    end
    for (int i = 0; i < held_n; i++) begin
      res.cube_index = pick[i];
      res.exact = hit[i];
      res.last_result = (i + 1 == held_n);
      assigned_q.push_back(res);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      rg_lv = RgReset;
      blue_lv = BlueReset;
      held_n = 0;
      assigned_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRgLevels: begin
            rg_lv = cfg_wdata_i;
          end
          CfgBlueLevels: begin
            blue_lv = cfg_wdata_i[BlueW-1:0];
          end
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (assigned_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: index %0d exact %0b last %0b",
                                    out_item_i.cube_index, out_item_i.exact,
                                    out_item_i.last_result));
        end else begin
          want = assigned_q.pop_front();
          if (out_item_i.cube_index !== want.cube_index) begin
            report_mismatch($sformatf("cube_index got %0d want %0d",
                                      out_item_i.cube_index, want.cube_index));
          end
          if (out_item_i.exact !== want.exact) begin
            report_mismatch($sformatf("exact got %0b want %0b (index %0d)",
                                      out_item_i.exact, want.exact, want.cube_index));
          end
          if (out_item_i.last_result !== want.last_result) begin
            report_mismatch($sformatf("last_result got %0b want %0b (index %0d)",
                                      out_item_i.last_result, want.last_result,
                                      want.cube_index));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // colors past a full store are dropped, a last mark still counts
        if (held_n < StoreDepth) begin
          held_colors[held_n] = {in_item_i.red, in_item_i.green, in_item_i.blue};
          held_n++;
        end
        if (in_item_i.final_color) begin
          assign_entries();
          held_n = 0;
        end
      end
    end
    backlog_o = assigned_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// Palette nearest color match: testbench top
// Loads batches of reserved colors under several level table settings, with
// random idle cycles on both channels and one long result hold-off, and
// gives the verdict from the checker's mismatch count and a stall timeout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import pncm_pkg::*; ();

  localparam int unsigned QuietLimit   = 80000;
  localparam int unsigned HoldCycles   = 3000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned StoreDepth   = 32;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgRgLevels;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  int unsigned         errors;
  int unsigned         backlog;

  logic [RgW-1:0]   rg_now = RgReset;
  logic [BlueW-1:0] blue_now = BlueReset;
  bit               calm = 1'b0;
  int unsigned      hold_req = 0;
  int unsigned      quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  palette_nearest_color_match i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  pncm_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .errors_o   (errors),
    .backlog_o  (backlog)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    int unsigned burst;
    int unsigned hold_seen;
    burst = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t mk(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic fin);
    in_item_t it;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.final_color = fin;
    return it;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int w;
    w = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (w < 0) begin
      w = 0;
    end else if (w > 255) begin
      w = 255;
    end
    return 8'(w);
  endfunction

  // mostly colors on or next to the current cube, some anywhere
  function automatic in_item_t pick_color();
    in_item_t   it;
    logic [7:0] j;
    j = 8'($urandom);
    it = mk(rg_now[8*j[2:0] +: 8], rg_now[8*j[5:3] +: 8], blue_now[8*j[7:6] +: 8], 1'b0);
    case ($urandom_range(0, 3))
      0, 1: ;
      2: begin
        it.red = nudge(it.red);
        it.green = nudge(it.green);
        it.blue = nudge(it.blue);
      end
      default: begin
        {it.red, it.green, it.blue} = 24'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic send_color(input in_item_t it, input bit gaps);
    if (gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_batch(input int unsigned n);
    bit       gaps;
    in_item_t it;
    gaps = $urandom_range(0, 2) != 0;
    for (int unsigned k = 0; k < n; k++) begin
      it = pick_color();
      it.final_color = (k + 1 == n);
      send_color(it, gaps);
    end
  endtask

  task automatic send_random(input int unsigned items);
    int unsigned done;
    int unsigned roll;
    int unsigned n;
    done = 0;
    while (done < items) begin
      roll = $urandom_range(0, 19);
      if (roll < 16) begin
        n = $urandom_range(1, 8);
      end else if (roll < 19) begin
        n = $urandom_range(9, StoreDepth);
      end else begin
        n = $urandom_range(StoreDepth + 1, StoreDepth + 4);
      end
      send_batch(n);
      done += n;
    end
  endtask

  // level tables change only once every result is out and the block is idle
  task automatic write_levels(input logic [RgW-1:0] rg, input logic [BlueW-1:0] bl);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CfgRgLevels;
    cfg_wdata <= rg;
    @(negedge clk);
    cfg_idx <= CfgBlueLevels;
    cfg_wdata <= {32'($urandom), bl};
    @(negedge clk);
    cfg_we <= 1'b0;
    rg_now = rg;
    blue_now = bl;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset tables: single color, then exact hits, duplicates, ties, extremes
    send_color(mk(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
    send_color(mk(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'h12, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'h12, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'h24, 8'h49, 8'h55, 1'b0), 1'b0);
    send_color(mk(8'h24, 8'h49, 8'h55, 1'b0), 1'b0);
    send_color(mk(8'h01, 8'h02, 8'h03, 1'b0), 1'b0);
    send_color(mk(8'hFF, 8'h00, 8'hFF, 1'b0), 1'b0);
    send_color(mk(8'h00, 8'hFF, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
    send_color(mk(8'hFE, 8'hFF, 8'hFF, 1'b0), 1'b0);
    send_color(mk(8'h80, 8'h80, 8'h80, 1'b0), 1'b0);
    send_color(mk(8'hA5, 8'h5A, 8'hC3, 1'b1), 1'b0);

    // full store: last mark on the first dropped color, then past it
    send_batch(StoreDepth + 1);
    send_batch(StoreDepth + 3);

    // all levels zero: every cube entry is black
    write_levels('0, '0);
    send_color(mk(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'h01, 8'h00, 8'h00, 1'b0), 1'b0);
    send_color(mk(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
    send_random(24);

    write_levels('1, '1);
    send_random(28);

    // few distinct levels, lots of ties
    write_levels({4{16'($urandom)}}, {2{16'($urandom)}});
    send_random(28);

    // hold the result side while the next batch is offered
    write_levels({$urandom, $urandom}, $urandom);
    hold_req <= hold_req + 1;
    send_batch(4);
    send_batch(6);
    send_random(20);

    write_levels({$urandom, $urandom}, $urandom);
    calm <= 1'b1;
    send_random(28);

    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
